// ----- rtl/dlbp_pkg.sv -----
// Package for the definite-length block parser.
// Holds the phase, status and register index codes, character constants, register reset values
// and the length overflow value. No dependencies.
package dlbp_pkg;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_DIGIT   = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  // Block status codes reported with block_done
  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_OK         = 3'd1,
    ST_NO_MARKER  = 3'd2,
    ST_BAD_DIGIT  = 3'd3,
    ST_ZERO_DIGIT = 3'd4,
    ST_BAD_LENGTH = 3'd5,
    ST_BAD_SAMPLE = 3'd6
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_BLOCK_BYTES = 2'd0,
    REG_RESYNC_LIMIT    = 2'd1,
    REG_LIMIT_MAGNITUDE = 2'd2
  } reg_index_t;

  localparam int CFG_DATA_W = 31;

  // Characters
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Register reset values
  localparam logic [15:0] MAX_BLOCK_BYTES_RST = 16'd64000;
  localparam logic [15:0] RESYNC_LIMIT_RST    = 16'd2000;
  localparam logic [30:0] LIMIT_MAGNITUDE_RST = 31'h4348_0000; // 200.0 as float32

  // Length value flagged on overflow
  localparam logic [16:0] LENGTH_OVF_VALUE = 17'h1_0000;

endpackage

// ----- rtl/definite_length_block_parser.sv -----
// Top level of the definite-length block parser ("#<n><len><payload>").
// Depends on dlbp_pkg for phase/status codes and constants.
//
// Usage:
//  - Input channel: one received byte per beat (rx_byte) with a restart flag that
//    abandons any block in progress before the byte is handled. A beat is taken
//    when in_valid is high and in_stall is low.
//  - Output channel: exactly one result beat per input beat, in order: payload
//    marking, last-byte flag, done flag, status and decoded length.
//  - Configuration: cfg_wr_en with cfg_index/cfg_data writes one register;
//    index 0 max_block_bytes, 1 resync_limit, 2 limit_magnitude. Write only
//    while the block holds no unfinished beat.
//  - Result path: a beat taken is held in the input register; its result is loaded
//    into the result register when the parser steps, which out_stall can hold back.
//  - Throughput: one byte per clock unless stalled by out_stall; every step is a
//    single update of the parser state between the input and result registers.
//  - Stall: when out_stall holds the result register full, the input register
//    holds too and in_stall goes high; no beat is lost or repeated.
//  - Reset (rst, synchronous): both registers empty, parser hunts for the marker,
//    registers return to 64000, 2000 and 200.0.
module definite_length_block_parser
  import dlbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  restart,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  payload_valid,
  output logic [7:0]            payload_byte,
  output logic                  payload_last,
  output logic                  block_done,
  output logic [2:0]            block_status,
  output logic [15:0]           block_bytes,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [15:0] max_block_bytes;
  logic [15:0] resync_limit;
  logic [30:0] limit_magnitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_bytes <= MAX_BLOCK_BYTES_RST;
      resync_limit    <= RESYNC_LIMIT_RST;
      limit_magnitude <= LIMIT_MAGNITUDE_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_BLOCK_BYTES: max_block_bytes <= cfg_data[15:0];
        REG_RESYNC_LIMIT:    resync_limit    <= cfg_data[15:0];
        REG_LIMIT_MAGNITUDE: limit_magnitude <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register and result register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       step;

  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte    <= rx_byte;
      in_restart <= restart;
    end
  end

  // Parser state
  phase_t      phase,           phase_next;
  logic [15:0] scan_count,      scan_count_next;
  logic [3:0]  digits_left,     digits_left_next;
  logic [16:0] length_acc,      length_acc_next;
  logic        length_overflow, length_overflow_next;
  logic        length_ended,    length_ended_next;
  logic [15:0] bytes_left,      bytes_left_next;
  logic [23:0] word_bytes,      word_bytes_next;
  logic [1:0]  byte_lane,       byte_lane_next;
  logic        sample_bad,      sample_bad_next;

  // Result of the current step
  logic        r_pv, r_pl, r_done;
  logic [7:0]  r_pb;
  status_t     r_status;
  logic [15:0] r_nbytes;

  // Scratch values
  logic        go_hunt;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [15:0] scan_inc;
  logic [15:0] scan_lim;
  logic [19:0] len_mul;
  logic [30:0] word_full;

  assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign digit_val = 4'(in_byte - CHAR_ZERO);
  assign scan_lim  = (resync_limit == 16'd0) ? 16'd1 : resync_limit;
  // magnitude bits only: the sign bit of the top byte is dropped
  assign word_full = {in_byte[6:0], word_bytes};

  always_comb begin
    // restart abandons the block before the byte is handled
    phase_next           = in_restart ? PH_HUNT : phase;
    scan_count_next      = in_restart ? 16'd0 : scan_count;
    digits_left_next     = in_restart ? 4'd0 : digits_left;
    length_overflow_next = in_restart ? 1'b0 : length_overflow;
    length_ended_next    = in_restart ? 1'b0 : length_ended;
    bytes_left_next      = in_restart ? 16'd0 : bytes_left;
    word_bytes_next      = in_restart ? 24'd0 : word_bytes;
    byte_lane_next       = in_restart ? 2'd0 : byte_lane;
    sample_bad_next      = in_restart ? 1'b0 : sample_bad;
    length_acc_next      = length_acc;

    r_pv     = 1'b0;
    r_pb     = 8'd0;
    r_pl     = 1'b0;
    r_done   = 1'b0;
    r_status = ST_BUSY;
    r_nbytes = 16'd0;
    go_hunt  = 1'b0;
    scan_inc = scan_count_next + 16'd1;
    len_mul  = {length_acc_next, 3'b000} + {2'b00, length_acc_next, 1'b0}
             + {16'd0, digit_val};

    unique case (phase_next)
      PH_HUNT: begin
        if (in_byte == CHAR_HASH) begin
          scan_count_next = 16'd0;
          phase_next      = PH_DIGIT;
        end else begin
          scan_count_next = scan_inc;
          if (scan_inc >= scan_lim) begin
            r_done   = 1'b1;
            r_status = ST_NO_MARKER;
            go_hunt  = 1'b1;
          end
        end
      end
      PH_DIGIT: begin
        if (!is_digit) begin
          r_done   = 1'b1;
          r_status = ST_BAD_DIGIT;
          go_hunt  = 1'b1;
        end else if (in_byte == CHAR_ZERO) begin
          r_done   = 1'b1;
          r_status = ST_ZERO_DIGIT;
          go_hunt  = 1'b1;
        end else begin
          digits_left_next     = digit_val;
          length_acc_next      = 17'd0;
          length_overflow_next = 1'b0;
          length_ended_next    = 1'b0;
          phase_next           = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        // first non-digit ends the value; later characters only count down
        if (!length_ended_next) begin
          if (is_digit) begin
            if (!length_overflow_next) begin
              if (len_mul > 20'h0_FFFF) begin
                length_overflow_next = 1'b1;
                length_acc_next      = LENGTH_OVF_VALUE;
              end else begin
                length_acc_next = len_mul[16:0];
              end
            end
          end else begin
            length_ended_next = 1'b1;
          end
        end
        digits_left_next = digits_left_next - 4'd1;
        if (digits_left_next == 4'd0) begin
          if (length_overflow_next || (length_acc_next == 17'd0) ||
              (length_acc_next > {1'b0, max_block_bytes})) begin
            r_done   = 1'b1;
            r_status = ST_BAD_LENGTH;
            go_hunt  = 1'b1;
          end else begin
            bytes_left_next = length_acc_next[15:0];
            word_bytes_next = 24'd0;
            byte_lane_next  = 2'd0;
            sample_bad_next = 1'b0;
            phase_next      = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        r_pv = 1'b1;
        r_pb = in_byte;
        // little-endian float32 gathering and magnitude check
        case (byte_lane_next)
          2'd3: begin
            if (word_full[30:0] > limit_magnitude) sample_bad_next = 1'b1;
            word_bytes_next = 24'd0;
            byte_lane_next  = 2'd0;
          end
          2'd2: begin
            word_bytes_next[23:16] = in_byte;
            byte_lane_next         = 2'd3;
          end
          2'd1: begin
            word_bytes_next[15:8] = in_byte;
            byte_lane_next        = 2'd2;
          end
          default: begin
            word_bytes_next[7:0] = in_byte;
            byte_lane_next       = 2'd1;
          end
        endcase
        bytes_left_next = bytes_left_next - 16'd1;
        if (bytes_left_next == 16'd0) begin
          r_pl    = 1'b1;
          r_done  = 1'b1;
          go_hunt = 1'b1;
          if (sample_bad_next) begin
            r_status = ST_BAD_SAMPLE;
          end else begin
            r_status = ST_OK;
            r_nbytes = length_acc_next[15:0];
          end
        end
      end
      default: ;
    endcase

    // finish or failure: back to the marker hunt
    if (go_hunt) begin
      phase_next           = PH_HUNT;
      scan_count_next      = 16'd0;
      digits_left_next     = 4'd0;
      length_overflow_next = 1'b0;
      length_ended_next    = 1'b0;
      bytes_left_next      = 16'd0;
      word_bytes_next      = 24'd0;
      byte_lane_next       = 2'd0;
      sample_bad_next      = 1'b0;
    end
  end

  // State update on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      scan_count      <= 16'd0;
      digits_left     <= 4'd0;
      length_acc      <= 17'd0;
      length_overflow <= 1'b0;
      length_ended    <= 1'b0;
      bytes_left      <= 16'd0;
      word_bytes      <= 24'd0;
      byte_lane       <= 2'd0;
      sample_bad      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      scan_count      <= scan_count_next;
      digits_left     <= digits_left_next;
      length_acc      <= length_acc_next;
      length_overflow <= length_overflow_next;
      length_ended    <= length_ended_next;
      bytes_left      <= bytes_left_next;
      word_bytes      <= word_bytes_next;
      byte_lane       <= byte_lane_next;
      sample_bad      <= sample_bad_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      payload_valid <= r_pv;
      payload_byte  <= r_pb;
      payload_last  <= r_pl;
      block_done    <= r_done;
      block_status  <= r_status;
      block_bytes   <= r_nbytes;
    end
  end

endmodule

// ----- sim/dlbp_checker.sv -----
`timescale 1ns / 1ps
// Checker for the definite-length block parser: watches both channels and the
// register port, predicts each result beat and compares it field by field.
// Depends on dlbp_pkg for phase, status and register codes and character constants.
module dlbp_checker
  import dlbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  restart,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  payload_valid,
  input  logic [7:0]            payload_byte,
  input  logic                  payload_last,
  input  logic                  block_done,
  input  logic [2:0]            block_status,
  input  logic [15:0]           block_bytes,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_owed
);

  typedef struct packed {
    logic        pv;
    logic [7:0]  pb;
    logic        pl;
    logic        done;
    status_t     status;
    logic [15:0] nbytes;
  } beat_result_t;

  beat_result_t pending_results[$];

  // register copies
  logic [15:0] max_bytes;
  logic [15:0] resync_lim;
  logic [30:0] mag_limit;

  // parser state
  phase_t      phase;
  logic [15:0] scan_cnt;
  logic [3:0]  digits_left;
  logic [16:0] len_acc;
  logic        len_ovf;
  logic        len_ended;
  logic [15:0] bytes_left;
  logic [23:0] word_acc;
  logic [1:0]  lane;
  logic        sample_bad;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  // back to the marker hunt with a fresh scan count
  function automatic void back_to_hunt();
    phase       = PH_HUNT;
    scan_cnt    = '0;
    digits_left = '0;
    len_ovf     = 1'b0;
    len_ended   = 1'b0;
    bytes_left  = '0;
    word_acc    = '0;
    lane        = '0;
    sample_bad  = 1'b0;
  endfunction

  // one parser step for one received byte
  function automatic beat_result_t parse_byte(logic [7:0] b, logic rs);
    beat_result_t r;
    logic [15:0]  lim;
    int unsigned  v;
    logic [31:0]  word;
    r        = '0;
    r.status = ST_BUSY;
    if (rs) back_to_hunt();
    case (phase)
      PH_HUNT: begin
        if (b == CHAR_HASH) begin
          scan_cnt = '0;
          phase    = PH_DIGIT;
        end else begin
          // a zero limit acts as one
          lim      = (resync_lim == 16'd0) ? 16'd1 : resync_lim;
          scan_cnt = scan_cnt + 16'd1;
          if (scan_cnt >= lim) begin
            r.done   = 1'b1;
            r.status = ST_NO_MARKER;
            back_to_hunt();
          end
        end
      end
      PH_DIGIT: begin
        if (b < CHAR_ZERO || b > CHAR_NINE) begin
          r.done   = 1'b1;
          r.status = ST_BAD_DIGIT;
          back_to_hunt();
        end else if (b == CHAR_ZERO) begin
          r.done   = 1'b1;
          r.status = ST_ZERO_DIGIT;
          back_to_hunt();
        end else begin
          digits_left = 4'(b - CHAR_ZERO);
          len_acc     = '0;
          len_ovf     = 1'b0;
          len_ended   = 1'b0;
          phase       = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        // first non-digit ends the value; the rest are swallowed
        if (!len_ended) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            if (!len_ovf) begin
              v = 32'(len_acc) * 10 + 32'(b - CHAR_ZERO);
              if (v > 32'hFFFF) begin
                len_ovf = 1'b1;
                v       = 32'(LENGTH_OVF_VALUE);
              end
              len_acc = 17'(v);
            end
          end else begin
            len_ended = 1'b1;
          end
        end
        digits_left = digits_left - 4'd1;
        if (digits_left == 4'd0) begin
          if (len_ovf || len_acc == '0 || len_acc > {1'b0, max_bytes}) begin
            r.done   = 1'b1;
            r.status = ST_BAD_LENGTH;
            back_to_hunt();
          end else begin
            bytes_left = len_acc[15:0];
            word_acc   = '0;
            lane       = '0;
            sample_bad = 1'b0;
            phase      = PH_PAYLOAD;
          end
        end
      end
      default: begin
        r.pv = 1'b1;
        r.pb = b;
        // little-endian float32 words; trailing bytes go unchecked
        if (lane == 2'd3) begin
          word = {b, word_acc};
          if (word[30:0] > mag_limit) sample_bad = 1'b1;
          word_acc = '0;
          lane     = '0;
        end else begin
          word_acc[8*lane +: 8] = b;
          lane = lane + 2'd1;
        end
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          r.pl   = 1'b1;
          r.done = 1'b1;
          if (sample_bad) begin
            r.status = ST_BAD_SAMPLE;
          end else begin
            r.status = ST_OK;
            r.nbytes = len_acc[15:0];
          end
          back_to_hunt();
        end
      end
    endcase
    return r;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin : monitor
    beat_result_t want;
    if (rst) begin
      max_bytes  = MAX_BLOCK_BYTES_RST;
      resync_lim = RESYNC_LIMIT_RST;
      mag_limit  = LIMIT_MAGNITUDE_RST;
      len_acc    = '0;
      back_to_hunt();
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("payload_valid", want.pv, payload_valid);
          compare_field("payload_byte", want.pb, payload_byte);
          compare_field("payload_last", want.pl, payload_last);
          compare_field("block_done", want.done, block_done);
          compare_field("block_status", want.status, block_status);
          compare_field("block_bytes", want.nbytes, block_bytes);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(parse_byte(rx_byte, restart));
      if (cfg_wr_en) begin
        case (reg_index_t'(cfg_index))
          REG_MAX_BLOCK_BYTES: max_bytes  = cfg_data[15:0];
          REG_RESYNC_LIMIT:    resync_lim = cfg_data[15:0];
          REG_LIMIT_MAGNITUDE: mag_limit  = cfg_data[30:0];
          default: ;
        endcase
      end
    end
    results_owed = pending_results.size();
  end

endmodule

// ----- sim/tb_definite_length_block_parser.sv -----
`timescale 1ns / 1ps
// Testbench top for the definite-length block parser: drives reply bytes,
// register writes and output stalls, and gives the verdict.
// Depends on dlbp_pkg, definite_length_block_parser and dlbp_checker.
module tb_definite_length_block_parser
  import dlbp_pkg::*;
();

  localparam int IDLE_LIMIT = 4000;

  // length field flaws
  localparam int FL_NONE = 0;
  localparam int FL_STOP = 1;
  localparam int FL_OVF  = 2;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            rx_byte;
  logic                  restart;
  logic                  out_valid;
  logic                  out_stall;
  logic                  payload_valid;
  logic [7:0]            payload_byte;
  logic                  payload_last;
  logic                  block_done;
  logic [2:0]            block_status;
  logic [15:0]           block_bytes;
  logic                  cfg_wr_en;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          fail_count;
  int          results_owed;
  int          sent;
  int          idle_cycles;
  int          stall_left;
  bit          calm;
  logic [15:0] cur_max;
  logic [30:0] cur_mag;

  definite_length_block_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .payload_valid(payload_valid), .payload_byte(payload_byte),
    .payload_last(payload_last), .block_done(block_done),
    .block_status(block_status), .block_bytes(block_bytes),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dlbp_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .payload_valid(payload_valid), .payload_byte(payload_byte),
    .payload_last(payload_last), .block_done(block_done),
    .block_status(block_status), .block_bytes(block_bytes),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one; none in calm stretches
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  always @(negedge clk) begin : stall_gen
    int g;
    if (rst) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      g = pick_gap();
      if (g > 0 && $urandom_range(0, 3) == 0) begin
        out_stall  = 1'b1;
        stall_left = g - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("definite_length_block_parser verification failed");
        $finish;
      end
    end
  end

  // one input beat, after an optional gap; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    restart  = rs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic rand_restart();
    return ($urandom_range(0, 199) == 0);
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  function automatic int count_digits(int unsigned v);
    int n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // float32 pattern: mostly in range, with limit edges, Inf and NaN mixed in
  function automatic logic [31:0] sample_word();
    int unsigned r;
    logic [30:0] mag;
    r = $urandom_range(0, 99);
    if (r < 75)      mag = 31'($urandom_range(0, cur_mag));
    else if (r < 80) mag = cur_mag;
    else if (r < 86) mag = 31'h7F80_0000;
    else if (r < 90) mag = 31'h7FC0_0000 | 31'($urandom_range(0, 32'h3F_FFFF));
    else if (r < 95) mag = cur_mag + 31'd1;
    else             mag = 31'($urandom);
    return {1'($urandom), mag};
  endfunction

  // '#', digit count, length field, then pay payload bytes
  task automatic send_frame(input int unsigned len, input int ndig, input int flaw,
                            input int pay);
    logic [7:0]  lc [9];
    int unsigned v;
    logic [31:0] w;
    v = len;
    for (int i = ndig - 1; i >= 0; i--) begin
      lc[i] = CHAR_ZERO + 8'(v % 10);
      v     = v / 10;
    end
    if (flaw == FL_STOP) begin
      lc[$urandom_range(0, ndig - 1)] = non_digit();
    end else if (flaw == FL_OVF) begin
      if (ndig == 5 && $urandom_range(0, 1) == 1) begin
        lc[0] = "6"; lc[1] = "5"; lc[2] = "5"; lc[3] = "3"; lc[4] = "6";
      end else begin
        for (int i = 0; i < ndig; i++) lc[i] = CHAR_NINE;
      end
    end
    send_byte(CHAR_HASH, rand_restart());
    send_byte(CHAR_ZERO + 8'(ndig), rand_restart());
    for (int i = 0; i < ndig; i++) send_byte(lc[i], rand_restart());
    for (int i = 0; i < pay; i++) begin
      if (i % 4 == 0) w = sample_word();
      send_byte(w[8*(i%4) +: 8], rand_restart());
    end
  endtask

  // register write once every outstanding result has arrived
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    in_valid = 1'b0;
    wait (results_owed == 0);
    repeat (3) @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_MAX_BLOCK_BYTES) cur_max = val[15:0];
    if (idx == REG_LIMIT_MAGNITUDE) cur_mag = val[30:0];
  endtask

  // random traffic: mostly well-formed blocks, the rest broken headers and noise
  task automatic random_traffic(input int beats);
    int unsigned r, len, hi;
    int ndig, target;
    target = sent + beats;
    while (sent < target) begin
      r  = $urandom_range(0, 99);
      hi = (cur_max < 24) ? cur_max + 1 : 24;
      if ($urandom_range(0, 19) == 0) hi = (cur_max < 300) ? cur_max + 1 : 300;
      len  = $urandom_range(1, hi);
      ndig = count_digits(len) + $urandom_range(0, 2);
      if (ndig > 9) ndig = 9;
      if (r < 62) begin
        send_frame(len, ndig, FL_NONE, len);
      end else if (r < 68) begin
        send_byte(CHAR_HASH, 1'b0);
        send_byte(($urandom_range(0, 1) == 1) ? CHAR_ZERO : non_digit(), 1'b0);
      end else if (r < 76) begin
        send_frame(len, (ndig < 2) ? 2 : ndig, FL_STOP, len);
      end else if (r < 82) begin
        send_frame(0, $urandom_range(5, 9), FL_OVF, 0);
      end else if (r < 85) begin
        send_frame(0, $urandom_range(1, 9), FL_NONE, 0);
      end else if (r < 90) begin
        // large block abandoned by a restart part way through
        send_frame($urandom_range(25, 65535), 5, FL_NONE, $urandom_range(3, 12));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), rand_restart());
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    restart   = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sent      = 0;
    calm      = 1'b0;
    cur_max   = MAX_BLOCK_BYTES_RST;
    cur_mag   = LIMIT_MAGNITUDE_RST;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: sample exactly at the limit, one just over it with sign set
    send_byte(CHAR_HASH, 1'b0); send_byte("1", 1'b0); send_byte("4", 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h48, 1'b0); send_byte(8'h43, 1'b0);
    send_byte(CHAR_HASH, 1'b0); send_byte("1", 1'b0); send_byte("4", 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h48, 1'b0); send_byte(8'hC3, 1'b0);
    // bad digit count, zero digit count, zero length
    send_byte(CHAR_HASH, 1'b0); send_byte("A", 1'b0);
    send_byte(CHAR_HASH, 1'b0); send_byte(CHAR_ZERO, 1'b0);
    send_byte(CHAR_HASH, 1'b0); send_byte("2", 1'b0);
    send_byte(CHAR_ZERO, 1'b0); send_byte(CHAR_ZERO, 1'b0);
    // restart abandons a block just opened
    send_byte(CHAR_HASH, 1'b0); send_byte("5", 1'b1);

    random_traffic(280);

    // smallest limits: one-byte blocks, every stray byte a resync failure
    write_reg(REG_MAX_BLOCK_BYTES, 31'd1);
    write_reg(REG_RESYNC_LIMIT, 31'd1);
    write_reg(REG_LIMIT_MAGNITUDE, 31'd0);
    random_traffic(220);

    // largest limits, no idling on either side
    write_reg(REG_MAX_BLOCK_BYTES, 31'd65535);
    write_reg(REG_RESYNC_LIMIT, 31'd65535);
    write_reg(REG_LIMIT_MAGNITUDE, 31'h7FFF_FFFF);
    calm = 1'b1;
    random_traffic(300);
    calm = 1'b0;

    // zero resync limit, sample limit of 1.0
    write_reg(REG_MAX_BLOCK_BYTES, 31'd16);
    write_reg(REG_RESYNC_LIMIT, 31'd0);
    write_reg(REG_LIMIT_MAGNITUDE, 31'h3F80_0000);
    random_traffic(300);

    write_reg(REG_MAX_BLOCK_BYTES, 31'd40);
    write_reg(REG_RESYNC_LIMIT, 31'd7);
    write_reg(REG_LIMIT_MAGNITUDE, 31'(LIMIT_MAGNITUDE_RST));
    random_traffic(300);

    // drain
    in_valid = 1'b0;
    wait (results_owed == 0);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("definite_length_block_parser verification clean");
    end else begin
      $display("definite_length_block_parser verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dlbp_pkg.sv
rtl/definite_length_block_parser.sv
sim/dlbp_checker.sv
sim/tb_definite_length_block_parser.sv
